### design/slcan_pkg.sv
// Shared types, character codes and helpers for the serial CAN line encoder.
// No dependencies; every other design file imports this package.
`default_nettype none

package slcan_pkg;

  localparam int MAX_DATA_BYTES = 8;

  localparam int ID_W      = 32;
  localparam int LEN_W     = 4;
  localparam int PAYLOAD_W = 64;
  localparam int TIME_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_STAMP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_STAMP_EACH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAMP_PERIODIC = 2'd1;

  localparam logic [CHAR_W-1:0] CHAR_CR   = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_T    = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_Y    = 8'h59;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;

  typedef enum logic {
    KIND_FRAME,
    KIND_STAMP
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_ID,
    ST_LEN,
    ST_DATA,
    ST_TIME,
    ST_CR
  } state_t;

  typedef struct packed {
    kind_t                  kind;
    logic [LEN_W-1:0]       len;
    logic                   stamp;
    logic [ID_W-1:0]        frame_id;
    logic [PAYLOAD_W-1:0]   payload;
    logic [TIME_W-1:0]      time_ms;
  } desc_t;

  localparam logic [CHAR_W-1:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    return HEX_DIGITS[nib];
  endfunction

endpackage

`default_nettype wire

### design/slcan_front.sv
// Front end: configuration registers, item intake and classification.
// Depends on slcan_pkg; feeds descriptors into slcan_fifo.
`default_nettype none

module slcan_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [slcan_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                            cfg_data,
  input  wire logic                            item_valid,
  input  wire logic                            q_full,
  output logic                                 item_stall,
  input  wire logic                            cmd,
  input  wire logic [slcan_pkg::ID_W-1:0]      frame_id,
  input  wire logic [slcan_pkg::LEN_W-1:0]     data_len,
  input  wire logic [slcan_pkg::PAYLOAD_W-1:0] payload,
  input  wire logic [slcan_pkg::TIME_W-1:0]    time_ms,
  output logic                                 q_push,
  output slcan_pkg::desc_t                     q_desc
);
  import slcan_pkg::*;

  logic stamp_each_frame;
  logic stamp_periodic;

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_each_frame <= 1'b0;
      stamp_periodic   <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_STAMP_EACH) begin
        stamp_each_frame <= cfg_data;
      end
      if (cfg_index == CFG_STAMP_PERIODIC) begin
        stamp_periodic <= cfg_data;
      end
    end
  end

  assign item_stall = q_full;

  // drop time-stamp transactions while periodic reporting is off
  assign q_push = item_valid && !item_stall && (cmd == CMD_FRAME || stamp_periodic);

  always_comb begin
    q_desc.kind     = (cmd == CMD_STAMP) ? KIND_STAMP : KIND_FRAME;
    q_desc.len      = (data_len > LEN_W'(MAX_DATA_BYTES)) ? LEN_W'(MAX_DATA_BYTES) : data_len;
    q_desc.stamp    = stamp_each_frame;
    q_desc.frame_id = frame_id;
    q_desc.payload  = payload;
    q_desc.time_ms  = time_ms;
  end

endmodule

`default_nettype wire

### design/slcan_fifo.sv
// Two-entry descriptor queue between front end and serialiser.
// Depends on slcan_pkg for the descriptor type.
`default_nettype none

module slcan_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire slcan_pkg::desc_t  push_desc,
  output logic                   full,
  input  wire logic              pop,
  output logic                   q_valid,
  output slcan_pkg::desc_t       q_desc
);
  import slcan_pkg::*;

  desc_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_desc  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

endmodule

`default_nettype wire

### design/slcan_back.sv
// Serialiser: walks one descriptor through its line, one character per cycle while char_stall is low.
// Depends on slcan_pkg; drains slcan_fifo into the registered character output.
`default_nettype none

module slcan_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  input  wire slcan_pkg::desc_t             q_desc,
  output logic                              q_pop,
  output logic                              char_valid,
  input  wire logic                         char_stall,
  output logic [slcan_pkg::CHAR_W-1:0]      out_char,
  output logic                              last
);
  import slcan_pkg::*;

  state_t                 state;
  state_t                 state_next;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       cnt_next;
  kind_t                  kind;
  logic [LEN_W-1:0]       len;
  logic                   stamp;
  logic [ID_W-1:0]        id_sh;
  logic [PAYLOAD_W-1:0]   data_sh;
  logic [TIME_W-1:0]      time_sh;
  logic                   adv;
  logic [CHAR_W-1:0]      cur_char;
  logic                   cur_last;
  logic [LEN_W:0]         data_span;

  assign adv       = (state != ST_IDLE) && (!char_valid || !char_stall);
  assign q_pop     = q_valid && (state == ST_IDLE || (state == ST_CR && adv));
  assign data_span = {len, 1'b0} - (LEN_W+1)'(1);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (adv) begin
          if (kind == KIND_STAMP) begin
            state_next = ST_TIME;
            cnt_next   = CNT_W'(3);
          end else begin
            state_next = ST_ID;
            cnt_next   = CNT_W'(7);
          end
        end
      end
      ST_ID: begin
        if (adv) begin
          cnt_next = cnt - CNT_W'(1);
          if (cnt == '0) begin
            state_next = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (adv) begin
          if (len != '0) begin
            state_next = ST_DATA;
            cnt_next   = data_span[CNT_W-1:0];
          end else if (stamp) begin
            state_next = ST_TIME;
            cnt_next   = CNT_W'(3);
          end else begin
            state_next = ST_CR;
          end
        end
      end
      ST_DATA: begin
        if (adv) begin
          cnt_next = cnt - CNT_W'(1);
          if (cnt == '0) begin
            if (stamp) begin
              state_next = ST_TIME;
              cnt_next   = CNT_W'(3);
            end else begin
              state_next = ST_CR;
            end
          end
        end
      end
      ST_TIME: begin
        if (adv) begin
          cnt_next = cnt - CNT_W'(1);
          if (cnt == '0) begin
            state_next = ST_CR;
          end
        end
      end
      ST_CR: begin
        if (adv) begin
          state_next = q_valid ? ST_HEAD : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cur_char = CHAR_CR;
    cur_last = 1'b0;
    case (state)
      ST_HEAD: cur_char = (kind == KIND_STAMP) ? CHAR_Y : CHAR_T;
      ST_ID:   cur_char = hex_char(id_sh[ID_W-1 -: 4]);
      ST_LEN:  cur_char = CHAR_ZERO + CHAR_W'(len);
      ST_DATA: cur_char = hex_char(data_sh[PAYLOAD_W-1 -: 4]);
      ST_TIME: cur_char = hex_char(time_sh[TIME_W-1 -: 4]);
      ST_CR: begin
        cur_char = CHAR_CR;
        cur_last = 1'b1;
      end
      default: begin
        cur_char = CHAR_CR;
        cur_last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      char_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (adv) begin
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_char <= cur_char;
      last     <= cur_last;
    end
    if (q_pop) begin
      kind    <= q_desc.kind;
      len     <= q_desc.len;
      stamp   <= q_desc.stamp;
      id_sh   <= q_desc.frame_id;
      data_sh <= q_desc.payload;
      time_sh <= q_desc.time_ms;
    end else if (adv) begin
      if (state == ST_ID) begin
        id_sh <= id_sh << 4;
      end
      if (state == ST_DATA) begin
        data_sh <= data_sh << 4;
      end
      if (state == ST_TIME) begin
        time_sh <= time_sh << 4;
      end
    end
  end

endmodule

`default_nettype wire

### design/slcan_frame_ascii_encoder.sv
// Top level of the serial CAN ASCII line encoder: front end, queue, serialiser.
// Depends on slcan_pkg, slcan_front, slcan_fifo and slcan_back.
//
//   channel   handshake                 payload
//   ------    ---------                 -------
//   item      item_valid / item_stall   cmd, frame_id, data_len, payload, time_ms
//   char      char_valid / char_stall   out_char, last
//   cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One character leaves per cycle when char_stall is low: a frame line is
// 11 + 2*len characters (+4 with stamping), a Y line 6, laid out by the serialiser's
// character sequencer. A two-entry queue lets items arrive while a line is
// still going out. Reset clears configuration, queue and sequencer at once.
// cfg_ready is always high.
`default_nettype none

module slcan_frame_ascii_encoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [slcan_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                            cfg_data,
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire logic                            cmd,
  input  wire logic [slcan_pkg::ID_W-1:0]      frame_id,
  input  wire logic [slcan_pkg::LEN_W-1:0]     data_len,
  input  wire logic [slcan_pkg::PAYLOAD_W-1:0] payload,
  input  wire logic [slcan_pkg::TIME_W-1:0]    time_ms,
  output logic                                 char_valid,
  input  wire logic                            char_stall,
  output logic [slcan_pkg::CHAR_W-1:0]         out_char,
  output logic                                 last
);
  import slcan_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  desc_t push_desc;
  desc_t q_desc;

  assign cfg_ready = 1'b1;

  slcan_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .q_full     (q_full),
    .item_stall (item_stall),
    .cmd        (cmd),
    .frame_id   (frame_id),
    .data_len   (data_len),
    .payload    (payload),
    .time_ms    (time_ms),
    .q_push     (q_push),
    .q_desc     (push_desc)
  );

  slcan_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_desc    (q_desc)
  );

  slcan_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_desc     (q_desc),
    .q_pop      (q_pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .out_char   (out_char),
    .last       (last)
  );

`ifndef SYNTHESIS
  a_last_is_cr: assert property (@(posedge clk) disable iff (rst)
    (char_valid && last) |-> (out_char == CHAR_CR))
    else $error("line end without carriage return");

  a_frame_queued: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && cmd == CMD_FRAME) |=> q_valid)
    else $error("accepted frame missing from queue");

  a_line_start: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !char_stall && last) |=>
      (!char_valid || out_char == CHAR_T || out_char == CHAR_Y))
    else $error("line does not open with T or Y");
`endif

endmodule

`default_nettype wire
